// ----- hw/rtl/vertex_component_to_float_assert.svh -----
`ifndef VERTEX_COMPONENT_TO_FLOAT_ASSERT_SVH
`define VERTEX_COMPONENT_TO_FLOAT_ASSERT_SVH

// implication checked in the same cycle
`define VCF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vcf check failed");

// implication checked in the following cycle
`define VCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vcf check failed");

`endif

// ----- hw/rtl/vcf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package vcf_pkg;

  localparam int RawW = 64;
  localparam int FloatW = 32;
  localparam int FmtW = 4;
  localparam int CfgIdxW = 1;

  typedef logic [FmtW-1:0] fmt_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam fmt_t FMT_FLOAT  = 4'd0;
  localparam fmt_t FMT_U8     = 4'd1;
  localparam fmt_t FMT_S8     = 4'd2;
  localparam fmt_t FMT_U16    = 4'd3;
  localparam fmt_t FMT_S16    = 4'd4;
  localparam fmt_t FMT_U32    = 4'd5;
  localparam fmt_t FMT_S32    = 4'd6;
  localparam fmt_t FMT_DOUBLE = 4'd7;

  localparam cfg_idx_t CFG_FORMAT = 1'b0;
  localparam cfg_idx_t CFG_NORM   = 1'b1;

  localparam logic [30:0] ONE_MAG = 31'h3F80_0000;
  localparam logic [30:0] INF_MAG = 31'h7F80_0000;

  function automatic logic [5:0] lzc32(input logic [31:0] v);
    logic [5:0] n;
    n = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 6'(31 - i);
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc16(input logic [15:0] v);
    logic [4:0] n;
    n = 5'd16;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) n = 5'(15 - i);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/vcf_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface vcf_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] raw_component;
  modport source (output valid, output raw_component, input ready);
  modport sink (input valid, input raw_component, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/vcf_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface vcf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] float_bits;
  modport source (output valid, output float_bits, input ready);
  modport sink (input valid, input float_bits, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/vertex_component_to_float.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  beat payload
// in_ch     in   raw_component [63:0]
// out_ch    out  float_bits [31:0]
// cfg_*     in   index 0 component_format, index 1 normalize_enable
//
// one beat per cycle sustained unless out_ch stalls; a beat passes through
// the input register and then the result register around the converter
// rst_n is synchronous; it clears the pipe valids and both config registers
// a stalled result freezes the whole pipe; in_ch.ready is low only then
module vertex_component_to_float (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               cfg_wr_en,
  input  vcf_pkg::cfg_idx_t cfg_index,
  input  wire [3:0]         cfg_wdata,
  vcf_in_if.sink            in_ch,
  vcf_out_if.source         out_ch
);
  import vcf_pkg::*;

  fmt_t        fmt_r;
  logic        norm_r;
  logic        s1_v_r;
  logic [63:0] raw_r;
  logic        out_v_r;
  logic [31:0] res_r;
  logic [31:0] res_nxt;
  logic        adv;

  assign adv = !out_v_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign out_ch.valid = out_v_r;
  assign out_ch.float_bits = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_FLOAT;
      norm_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FORMAT: fmt_r <= cfg_wdata;
        CFG_NORM:   norm_r <= cfg_wdata[0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_ch.valid;
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      raw_r <= in_ch.raw_component;
      res_r <= res_nxt;
    end
  end

  // integer path
  logic        i_neg;
  logic [31:0] i_mag;
  logic [31:0] i_sh;
  logic [5:0]  i_lz;
  logic        i_up;
  logic [31:0] i_res;
  logic [31:0] s8x;
  logic [31:0] s16x;

  always_comb begin
    s8x = {{24{raw_r[7]}}, raw_r[7:0]};
    s16x = {{16{raw_r[15]}}, raw_r[15:0]};
    i_neg = 1'b0;
    i_mag = raw_r[31:0];
    case (fmt_r)
      FMT_U8:  i_mag = {24'd0, raw_r[7:0]};
      FMT_U16: i_mag = {16'd0, raw_r[15:0]};
      FMT_S8: begin
        i_neg = raw_r[7];
        i_mag = i_neg ? (~s8x + 32'd1) : s8x;
      end
      FMT_S16: begin
        i_neg = raw_r[15];
        i_mag = i_neg ? (~s16x + 32'd1) : s16x;
      end
      FMT_S32: begin
        i_neg = raw_r[31];
        i_mag = i_neg ? (~raw_r[31:0] + 32'd1) : raw_r[31:0];
      end
      default: ;
    endcase
    i_lz = lzc32(i_mag);
    i_sh = i_mag << i_lz[4:0];
    i_up = i_sh[7] && ((|i_sh[6:0]) || i_sh[8]);
    i_res = {i_neg, {8'(8'd158 - {2'd0, i_lz}), i_sh[30:8]} + 31'(i_up)};
    if (i_mag == 32'd0) i_res = 32'd0;
  end

  // normalized path: v / (2^n - 1) is v repeated in n-bit groups
  logic        n_neg;
  logic [6:0]  m7;
  logic [14:0] m15;
  logic [7:0]  ns8;
  logic [15:0] ns16;
  logic [63:0] w8;
  logic [63:0] w16;
  logic [63:0] w7;
  logic [63:0] w15;
  logic [63:0] nw;
  logic [63:0] n_sh;
  logic [4:0]  n_lz;
  logic        n_min;
  logic [31:0] n_res;

  always_comb begin
    ns8 = ~raw_r[7:0] + 8'd1;
    ns16 = ~raw_r[15:0] + 16'd1;
    m7 = raw_r[7] ? ns8[6:0] : raw_r[6:0];
    m15 = raw_r[15] ? ns16[14:0] : raw_r[14:0];
    for (int i = 0; i < 64; i++) begin
      w8[63-i] = raw_r[7 - (i % 8)];
      w16[63-i] = raw_r[15 - (i % 16)];
      w7[63-i] = m7[6 - (i % 7)];
      w15[63-i] = m15[14 - (i % 15)];
    end
    n_neg = 1'b0;
    n_min = 1'b0;
    case (fmt_r)
      FMT_U8:  nw = w8;
      FMT_U16: nw = w16;
      FMT_S8: begin
        nw = w7;
        n_neg = raw_r[7];
        n_min = (raw_r[7:0] == 8'h80);
      end
      default: begin
        nw = w15;
        n_neg = raw_r[15];
        n_min = (raw_r[15:0] == 16'h8000);
      end
    endcase
    n_lz = lzc16(nw[63:48]);
    n_sh = nw << n_lz[3:0];
    n_res = {n_neg, {8'(8'd126 - {3'd0, n_lz}), n_sh[62:40]} + 31'(n_sh[39])};
    if (n_min) n_res = {1'b1, ONE_MAG};
    else if (nw[63:48] == 16'd0) n_res = 32'd0;
  end

  // double path
  logic        d_s;
  logic [10:0] d_ex;
  logic [51:0] d_fr;
  logic [11:0] d_be;
  logic [52:0] d_m;
  logic [5:0]  d_sm1;
  logic [52:0] d_x;
  logic [52:0] d_msk;
  logic        d_up;
  logic [31:0] d_res;

  always_comb begin
    d_s = raw_r[63];
    d_ex = raw_r[62:52];
    d_fr = raw_r[51:0];
    d_m = {1'b1, d_fr};
    d_be = {1'b0, d_ex} - 12'd896;
    d_sm1 = 6'd29;
    d_x = '0;
    d_msk = '0;
    d_up = 1'b0;
    if (d_ex == 11'h7FF) begin
      d_res = (d_fr == 52'd0) ? {d_s, INF_MAG} : {d_s, 8'hFF, 1'b1, d_fr[50:29]};
    end else if (d_ex == 11'd0) begin
      d_res = {d_s, 31'd0};
    end else if (!d_be[11] && d_be >= 12'd255) begin
      d_res = {d_s, INF_MAG};
    end else if (!d_be[11] && d_be != 12'd0) begin
      d_up = raw_r[28] && ((|raw_r[27:0]) || raw_r[29]);
      d_res = {d_s, {d_be[7:0], d_fr[51:29]} + 31'(d_up)};
    end else if (d_be[11] && d_be < 12'hFE8) begin
      d_res = {d_s, 31'd0};
    end else begin
      d_sm1 = 6'(6'd29 - d_be[5:0]);
      d_x = d_m >> d_sm1;
      d_msk = (53'd1 << d_sm1) - 53'd1;
      d_up = d_x[0] && ((|(d_m & d_msk)) || d_x[1]);
      d_res = {d_s, {8'd0, d_x[23:1]} + 31'(d_up)};
    end
  end

  always_comb begin
    case (fmt_r) inside
      FMT_FLOAT:  res_nxt = raw_r[31:0];
      FMT_U8, FMT_S8, FMT_U16, FMT_S16: res_nxt = norm_r ? n_res : i_res;
      FMT_U32, FMT_S32: res_nxt = i_res;
      FMT_DOUBLE: res_nxt = d_res;
      default:    res_nxt = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/vcf_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "vertex_component_to_float_assert.svh"
module vcf_checker (
  input wire clk,
  input wire rst_n,
  input wire in_valid,
  input wire in_ready,
  input wire out_valid,
  input wire out_ready,
  input wire [31:0] out_bits
);
  `VCF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_bits))
  `VCF_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_valid || out_ready, in_ready)
  `VCF_ASSERT_NOW(a_stall_blocks_input, clk, rst_n, out_valid && !out_ready, !in_ready)
endmodule

bind vertex_component_to_float vcf_checker u_vcf_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_bits(out_ch.float_bits)
);
`default_nettype wire
